FILE: hw/rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared definitions for the two-bit sprite blitter
// Command opcodes, pixel codes and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package tsb_pkg;

    // Command opcodes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Two-bit sprite pixel codes
    localparam logic [1:0] PIX_BLACK = 2'd0;
    localparam logic [1:0] PIX_GRAY  = 2'd1;
    localparam logic [1:0] PIX_WHITE = 2'd2;
    localparam logic [1:0] PIX_CLEAR = 2'd3;

    // Framebuffer address source
    typedef enum logic [1:0] {
        MS_FILL,
        MS_BYTE0,
        MS_BYTE1,
        MS_READ
    } t_mem_sel;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     begin_eval;
        logic     set_reject;
        logic     data_calc;
        logic     addr_calc;
        logic     mem_rd;
        logic     mem_wr;
        t_mem_sel mem_sel;
        logic     fill_ones;
        logic     read_take;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic data_ok;
        logic byte0_ok;
        logic byte1_ok;
        logic read_ok;
        logic fill_last;
    } t_stat;

endpackage

FILE: hw/rtl/tsb_if.sv
// ----------------------------------------------------------------------------
// tsb_if: channel interfaces of the two-bit sprite blitter
// Command input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tsb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic [15:0]        data_pair;
    logic [9:0]         read_address;

    modport source (
        output valid, opcode, pos_x, pos_y, sprite_width, sprite_height,
               data_pair, read_address,
        input  ready
    );
    modport sink (
        input  valid, opcode, pos_x, pos_y, sprite_width, sprite_height,
               data_pair, read_address,
        output ready
    );
endinterface

interface tsb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, read_data, rejected, input ready);
    modport sink (input valid, read_data, rejected, output ready);
endinterface

interface tsb_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/tsb_dp.sv
// ----------------------------------------------------------------------------
// tsb_dp: blitter datapath
// Holds the framebuffer, the sprite walk state and the result registers,
// and performs the steps the controller commands.
// ----------------------------------------------------------------------------
module tsb_dp import tsb_pkg::*; #(
    parameter int SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [7:0]  i_sprite_width,
    input  logic [7:0]  i_sprite_height,
    input  logic [15:0] i_data_pair,
    input  logic [9:0]  i_read_address,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    output logic [7:0]  o_read_data,
    output logic        o_rejected
);

    localparam int FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
    localparam int AW       = $clog2(FB_BYTES);
    localparam int IDX_W    = 14 + $clog2(SCREEN_WIDTH) + 3;

    localparam logic signed [16:0]      SW_S  = 17'(SCREEN_WIDTH);
    localparam logic signed [16:0]      SH_S  = 17'(SCREEN_HEIGHT);
    localparam logic signed [IDX_W-1:0] SW_I  = IDX_W'(SCREEN_WIDTH);
    localparam logic signed [IDX_W-1:0] FB_I  = IDX_W'(FB_BYTES);
    localparam logic [AW-1:0]           LAST_A = AW'(FB_BYTES - 1);

    // Eight 2-bit pixels to {set mask, clear mask}
    function automatic logic [15:0] f_masks(input logic [15:0] data, input logic gray_white);
        logic [7:0] msk_set;
        logic [7:0] msk_clr;
        logic [1:0] pix;
        msk_set = '0;
        msk_clr = '0;
        for (int k = 0; k < 8; k++) begin
            pix = data[2*k +: 2];
            if (pix == PIX_GRAY) begin
                pix = gray_white ? PIX_WHITE : PIX_BLACK;
            end
            msk_set[k] = (pix == PIX_WHITE);
            msk_clr[k] = (pix == PIX_BLACK);
        end
        return {msk_set, msk_clr};
    endfunction

    // Captured item
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic [7:0]         r_w;
    logic [7:0]         r_h;
    logic [15:0]        r_data;
    logic [9:0]         r_raddr;

    // Sprite walk state
    logic [15:0] r_org_x;
    logic [15:0] r_org_y;
    logic [7:0]  r_width_held;
    logic [7:0]  r_col_cnt;
    logic [7:0]  r_band_cnt;
    logic [12:0] r_pairs_left;
    logic        r_active;
    logic        r_gray_as_white;

    // Column placement
    logic signed [16:0] r_col;
    logic signed [13:0] r_band;
    logic [2:0]         r_shift;
    logic [15:0]        r_set16;
    logic [15:0]        r_clr16;
    logic               r_draw_ok;
    logic [AW-1:0]      r_addr0;
    logic [AW-1:0]      r_addr1;
    logic               r_ok0;
    logic               r_ok1;

    // Framebuffer and sweep
    logic [7:0]    r_mem [FB_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_fill_addr;

    // Result
    logic [7:0] r_res_data;
    logic       r_res_rej;
    logic [7:0] r_out_data;
    logic       r_out_rej;

    logic signed [17:0] w_x_end;
    logic signed [17:0] w_y_end;
    logic               w_off;
    logic [15:0]        w_prod;
    logic signed [16:0] w_col;
    logic signed [16:0] w_row;
    logic signed [13:0] w_band;
    logic [15:0]        w_msk;
    logic [8:0]         w_cc_next;
    logic signed [IDX_W-1:0] w_base;
    logic signed [IDX_W-1:0] w_next;
    logic [AW-1:0]      w_addr;
    logic [7:0]         w_wdata;

    // Begin: off-screen test and pair count
    assign w_x_end = {{2{r_px[15]}}, r_px} + $signed({10'd0, r_w});
    assign w_y_end = {{2{r_py[15]}}, r_py} + $signed({10'd0, r_h});
    assign w_off   = w_x_end[17] || ($signed({r_px[15], r_px}) >= SW_S) ||
                     w_y_end[17] || ($signed({r_py[15], r_py}) >= SH_S);
    assign w_prod  = {8'd0, r_w} * {8'd0, r_h};

    // Data: column and band of the current sprite column
    assign w_col     = $signed({r_org_x[15], r_org_x}) + $signed({9'd0, r_col_cnt});
    assign w_row     = $signed({r_org_y[15], r_org_y}) + $signed({6'd0, r_band_cnt, 3'd0});
    assign w_band    = $signed({r_org_y[15], r_org_y[15:3]}) + $signed({6'd0, r_band_cnt});
    assign w_msk     = f_masks(r_data, r_gray_as_white);
    assign w_cc_next = {1'b0, r_col_cnt} + 9'd1;

    // Byte indexes of the two target bytes
    assign w_base = IDX_W'(r_band) * SW_I + IDX_W'(r_col);
    assign w_next = w_base + SW_I;

    // Status
    assign o_stat.data_ok   = r_active && (r_pairs_left != '0);
    assign o_stat.byte0_ok  = r_ok0;
    assign o_stat.byte1_ok  = r_ok1;
    assign o_stat.read_ok   = (32'(r_raddr) < 32'(FB_BYTES));
    assign o_stat.fill_last = (r_fill_addr == LAST_A);

    // Memory address and write data
    always_comb begin
        case (i_cmd.mem_sel)
            MS_FILL: begin
                w_addr  = r_fill_addr;
                w_wdata = i_cmd.fill_ones ? 8'hFF : 8'h00;
            end
            MS_BYTE0: begin
                w_addr  = r_addr0;
                w_wdata = (r_rdata | r_set16[7:0]) & ~r_clr16[7:0];
            end
            MS_BYTE1: begin
                w_addr  = r_addr1;
                w_wdata = (r_rdata | r_set16[15:8]) & ~r_clr16[15:8];
            end
            MS_READ: begin
                w_addr  = AW'(r_raddr);
                w_wdata = r_rdata;
            end
            default: begin
                w_addr  = r_fill_addr;
                w_wdata = r_rdata;
            end
        endcase
    end

    // Single-port framebuffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_w     <= i_sprite_width;
            r_h     <= i_sprite_height;
            r_data  <= i_data_pair;
            r_raddr <= i_read_address;
        end
        if (i_cmd.data_calc) begin
            r_col     <= w_col;
            r_band    <= w_band;
            r_shift   <= r_org_y[2:0];
            r_set16   <= {8'd0, w_msk[15:8]} << r_org_y[2:0];
            r_clr16   <= {8'd0, w_msk[7:0]} << r_org_y[2:0];
            r_draw_ok <= !w_col[16] && (w_col < SW_S) && (w_row < SH_S);
        end
        if (i_cmd.addr_calc) begin
            r_addr0 <= w_base[AW-1:0];
            r_addr1 <= w_next[AW-1:0];
            r_ok0   <= r_draw_ok && !w_base[IDX_W-1] && (w_base < FB_I);
            r_ok1   <= r_draw_ok && (r_shift != 3'd0) &&
                       !w_next[IDX_W-1] && (w_next < FB_I);
        end
        if (i_cmd.capture) begin
            r_res_data <= '0;
            r_res_rej  <= 1'b0;
        end else begin
            if (i_cmd.begin_eval && w_off) begin
                r_res_rej <= 1'b1;
            end
            if (i_cmd.set_reject) begin
                r_res_rej <= 1'b1;
            end
            if (i_cmd.read_take) begin
                r_res_data <= r_rdata;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res_data;
            r_out_rej  <= r_res_rej;
        end
    end

    // Sprite state, configuration and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x         <= '0;
            r_org_y         <= '0;
            r_width_held    <= '0;
            r_col_cnt       <= '0;
            r_band_cnt      <= '0;
            r_pairs_left    <= '0;
            r_active        <= 1'b0;
            r_gray_as_white <= 1'b0;
            r_fill_addr     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gray_as_white <= i_cfg_data;
            end
            if (i_cmd.begin_eval) begin
                if (w_off) begin
                    r_active <= 1'b0;
                end else begin
                    r_org_x      <= r_px;
                    r_org_y      <= r_py;
                    r_width_held <= r_w;
                    r_col_cnt    <= '0;
                    r_band_cnt   <= '0;
                    r_pairs_left <= w_prod[15:3];
                    r_active     <= 1'b1;
                end
            end
            if (i_cmd.data_calc) begin
                r_pairs_left <= r_pairs_left - 13'd1;
                if (w_cc_next >= {1'b0, r_width_held}) begin
                    r_col_cnt  <= '0;
                    r_band_cnt <= r_band_cnt + 8'd1;
                end else begin
                    r_col_cnt <= w_cc_next[7:0];
                end
            end
            // sweep wraps so the next pass starts at byte zero
            if (i_cmd.mem_wr && (i_cmd.mem_sel == MS_FILL)) begin
                r_fill_addr <= (r_fill_addr == LAST_A) ? '0 : r_fill_addr + 1'b1;
            end
        end
    end

    assign o_read_data = r_out_data;
    assign o_rejected  = r_out_rej;

endmodule

FILE: hw/rtl/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// tsb_ctrl: blitter controller
// Sequences each command through the datapath and owns the input ready
// and output valid handshake signals.
// ----------------------------------------------------------------------------
module tsb_ctrl import tsb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_BEGIN,
        S_REJECT,
        S_CALC,
        S_ADDR,
        S_RD0,
        S_WR0,
        S_RD1,
        S_WR1,
        S_FILL,
        S_RDQ,
        S_RDT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mem_sel = MS_FILL;
        o_in_ready    = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.mem_wr = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_opcode)
                        OP_BEGIN: n_state = S_BEGIN;
                        OP_DATA:  n_state = i_stat.data_ok ? S_CALC : S_REJECT;
                        OP_CLEAR: n_state = S_FILL;
                        OP_READ:  n_state = S_RDQ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_BEGIN: begin
                o_cmd.begin_eval = 1'b1;
                n_state          = S_DONE;
            end
            S_REJECT: begin
                o_cmd.set_reject = 1'b1;
                n_state          = S_DONE;
            end
            S_CALC: begin
                o_cmd.data_calc = 1'b1;
                n_state         = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr_calc = 1'b1;
                n_state         = S_RD0;
            end
            // first target byte: read then merge
            S_RD0: begin
                o_cmd.mem_sel = MS_BYTE0;
                o_cmd.mem_rd  = i_stat.byte0_ok;
                if (i_stat.byte0_ok) begin
                    n_state = S_WR0;
                end else if (i_stat.byte1_ok) begin
                    n_state = S_RD1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WR0: begin
                o_cmd.mem_sel = MS_BYTE0;
                o_cmd.mem_wr  = 1'b1;
                n_state       = i_stat.byte1_ok ? S_RD1 : S_DONE;
            end
            // second target byte, one band lower
            S_RD1: begin
                o_cmd.mem_sel = MS_BYTE1;
                o_cmd.mem_rd  = 1'b1;
                n_state       = S_WR1;
            end
            S_WR1: begin
                o_cmd.mem_sel = MS_BYTE1;
                o_cmd.mem_wr  = 1'b1;
                n_state       = S_DONE;
            end
            S_FILL: begin
                o_cmd.mem_wr    = 1'b1;
                o_cmd.fill_ones = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_RDQ: begin
                o_cmd.mem_sel = MS_READ;
                o_cmd.mem_rd  = i_stat.read_ok;
                n_state       = S_RDT;
            end
            S_RDT: begin
                o_cmd.read_take = i_stat.read_ok;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/two_bit_sprite_blitter_unit.sv
// ----------------------------------------------------------------------------
// two_bit_sprite_blitter_unit: 2bpp sprite blitter, paged mono framebuffer
// Draws 2-bit sprites into an internal byte-per-column framebuffer.
// ----------------------------------------------------------------------------
// Channels: i_in takes one command per transaction (begin sprite, data pair,
// clear to white, read byte); o_out returns exactly one result per command
// (read_data, rejected). i_cfg writes gray_as_white and is always ready; write
// it only while no command is in flight.
// Sequence: one command at a time, from acceptance to result ready: begin
//   checks the position, rejected data sets the flag, read fetches the byte,
//   a data pair computes its column and addresses, then does one
//   read-modify-write of the single-port framebuffer for each of the up to
//   two bytes touched, and clear writes one byte per cycle. The next command
//   is taken the cycle after the result moves into the output register.
// Reset: a sweep over every byte zeroes the framebuffer; i_in.ready stays
// low until it ends.
// Stall: the result waits in the output register; one more command is taken
// and processed meanwhile, then the block holds until the output drains.
// ----------------------------------------------------------------------------
module two_bit_sprite_blitter_unit import tsb_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsb_in_if.sink    i_in,
    tsb_out_if.source o_out,
    tsb_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    // Controller
    tsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath
    tsb_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_pos_x         (i_in.pos_x),
        .i_pos_y         (i_in.pos_y),
        .i_sprite_width  (i_in.sprite_width),
        .i_sprite_height (i_in.sprite_height),
        .i_data_pair     (i_in.data_pair),
        .i_read_address  (i_in.read_address),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .o_read_data     (o_out.read_data),
        .o_rejected      (o_out.rejected)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign i_cfg.ready = 1'b1;

    // Single-port framebuffer: never read and write in one cycle
    a_mem_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.mem_rd && w_cmd.mem_wr))
        else $error("framebuffer read and write in the same cycle");

    // One command at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command accepted while another is in flight");

    // A merge write always follows the read of the same byte
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mem_wr && (w_cmd.mem_sel == MS_BYTE0 || w_cmd.mem_sel == MS_BYTE1))
        |-> $past(w_cmd.mem_rd))
        else $error("merge write without a preceding read");

    // No command is taken during a fill sweep
    a_fill_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mem_wr && w_cmd.mem_sel == MS_FILL) |-> !i_in.ready)
        else $error("input ready during framebuffer sweep");

endmodule

FILE: test/two_bit_sprite_blitter_unit_test.sv
// ----------------------------------------------------------------------------
// two_bit_sprite_blitter_unit_test: self-checking bench for the sprite blitter
// Drives begin, data pair, clear and read commands with random gaps and
// output stalls. Every result is checked against a behavioral framebuffer
// model that mirrors the sprite state and the gray mapping.
// ----------------------------------------------------------------------------
module two_bit_sprite_blitter_unit_test import tsb_pkg::*; ();

    localparam int SCR_W          = 128;
    localparam int SCR_H          = 64;
    localparam int FB_BYTES       = SCR_W * SCR_H / 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int FIRST_HOLD     = 150;
    localparam int SECOND_HOLD    = 420;
    localparam int NO_MORE_HOLDS  = 32'h7FFF_FFFF;

    typedef struct {
        logic [1:0]         opcode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         sprite_width;
        logic [7:0]         sprite_height;
        logic [15:0]        data_pair;
        logic [9:0]         read_address;
    } t_blit_cmd;

    typedef struct {
        logic [7:0] read_data;
        logic       rejected;
    } t_blit_result;

    logic i_clk;
    logic i_rst_n;

    tsb_in_if  cmd_if ();
    tsb_out_if res_if ();
    tsb_cfg_if cfg_if ();

    two_bit_sprite_blitter_unit #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // Commands waiting to be sent, results still owed by the block
    t_blit_cmd    cmd_queue[$];
    t_blit_result pending_results[$];

    // Framebuffer model and sprite state
    logic [7:0] frame_model [FB_BYTES];
    int         org_x;
    int         org_y;
    int         held_w;
    int         col_cnt;
    int         band_cnt;
    int         pairs_left;
    logic       sprite_on;
    logic       gray_white;

    int           err_count    = 0;
    int           result_count = 0;
    int           idle_cycles  = 0;
    int           next_hold_at = FIRST_HOLD;
    int           tx_gap;
    int           rx_wait;
    logic         cmd_taken;
    t_blit_cmd    seen_cmd;
    t_blit_cmd    next_cmd;
    t_blit_result want;

    // Stretches in which neither side idles at random
    wire calm_stretch = ((result_count / 40) % 3) == 1;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Framebuffer model
    // ------------------------------------------------------------------------
    function automatic void merge_into_frame(input int idx, input logic [7:0] set_m,
                                             input logic [7:0] clr_m);
        if (idx >= 0 && idx < FB_BYTES)
            frame_model[idx] = (frame_model[idx] | set_m) & ~clr_m;
    endfunction

    function automatic t_blit_result apply_command(input t_blit_cmd c);
        t_blit_result r;
        int           x, y, w, h, col, shift, base;
        logic [1:0]   pix;
        logic [15:0]  set_m, clr_m;
        r.read_data = 8'h00;
        r.rejected  = 1'b0;
        case (c.opcode)
            OP_BEGIN: begin
                x = int'(c.pos_x);
                y = int'(c.pos_y);
                w = int'(c.sprite_width);
                h = int'(c.sprite_height);
                // wholly off screen: drop any active sprite
                if (x + w < 0 || x >= SCR_W || y + h < 0 || y >= SCR_H) begin
                    sprite_on  = 1'b0;
                    r.rejected = 1'b1;
                end else begin
                    org_x      = x;
                    org_y      = y;
                    held_w     = w;
                    col_cnt    = 0;
                    band_cnt   = 0;
                    pairs_left = (w * h) / 8;
                    sprite_on  = 1'b1;
                end
            end
            OP_DATA: begin
                if (!sprite_on || pairs_left == 0) begin
                    r.rejected = 1'b1;
                end else begin
                    // pixel codes to set / clear masks, bit k is row k of the column
                    set_m = '0;
                    clr_m = '0;
                    for (int k = 0; k < 8; k++) begin
                        pix = c.data_pair[2*k +: 2];
                        if (pix == PIX_GRAY)
                            pix = gray_white ? PIX_WHITE : PIX_BLACK;
                        if (pix == PIX_WHITE)
                            set_m[k] = 1'b1;
                        else if (pix == PIX_BLACK)
                            clr_m[k] = 1'b1;
                    end
                    // clip to screen, then split over two bytes by row phase
                    col = org_x + col_cnt;
                    if (col >= 0 && col < SCR_W && org_y + band_cnt * 8 < SCR_H) begin
                        shift = org_y & 7;
                        base  = ((org_y >>> 3) + band_cnt) * SCR_W + col;
                        set_m = set_m << shift;
                        clr_m = clr_m << shift;
                        merge_into_frame(base, set_m[7:0], clr_m[7:0]);
                        if (shift != 0)
                            merge_into_frame(base + SCR_W, set_m[15:8], clr_m[15:8]);
                    end
                    pairs_left--;
                    col_cnt++;
                    if (col_cnt >= held_w) begin
                        col_cnt = 0;
                        band_cnt++;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < FB_BYTES; i++)
                    frame_model[i] = 8'hFF;
            end
            default: begin
                if (c.read_address < FB_BYTES)
                    r.read_data = frame_model[c.read_address];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command builders; fields a command does not use are random
    // ------------------------------------------------------------------------
    function automatic t_blit_cmd random_cmd(input logic [1:0] op);
        t_blit_cmd c;
        c.opcode        = op;
        c.pos_x         = 16'($urandom_range(0, 65535));
        c.pos_y         = 16'($urandom_range(0, 65535));
        c.sprite_width  = 8'($urandom_range(0, 255));
        c.sprite_height = 8'($urandom_range(0, 255));
        c.data_pair     = 16'($urandom_range(0, 65535));
        c.read_address  = 10'($urandom_range(0, 1023));
        return c;
    endfunction

    function automatic t_blit_cmd cmd_begin(input int x, input int y, input int w, input int h);
        t_blit_cmd c;
        c               = random_cmd(OP_BEGIN);
        c.pos_x         = x[15:0];
        c.pos_y         = y[15:0];
        c.sprite_width  = w[7:0];
        c.sprite_height = h[7:0];
        return c;
    endfunction

    function automatic t_blit_cmd cmd_data(input logic [15:0] d);
        t_blit_cmd c;
        c           = random_cmd(OP_DATA);
        c.data_pair = d;
        return c;
    endfunction

    function automatic t_blit_cmd cmd_read(input int a);
        t_blit_cmd c;
        c              = random_cmd(OP_READ);
        c.read_address = a[9:0];
        return c;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Random traffic: mostly complete sprites followed by reads of the area
    // ------------------------------------------------------------------------
    task automatic add_random_items(input int total);
        int added, r, x, y, w, h, n, extra, a;
        added = 0;
        while (added < total) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                x = $urandom_range(0, 159) - 24;
                y = $urandom_range(0, 95) - 24;
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 20);
                if ($urandom_range(0, 9) == 0) begin
                    w = $urandom_range(0, 255);
                    h = $urandom_range(0, 15);
                end
                n = (w * h) / 8;
                if (n > 24)
                    n = 24;
                extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                cmd_queue.push_back(cmd_begin(x, y, w, h));
                for (int i = 0; i < n + extra; i++)
                    cmd_queue.push_back(cmd_data(16'($urandom_range(0, 65535))));
                for (int i = 0; i < 3; i++) begin
                    a = ((y >>> 3) + int'($urandom_range(0, 2))) * SCR_W + x +
                        int'($urandom_range(0, w));
                    if (a < 0 || a >= FB_BYTES)
                        a = $urandom_range(0, FB_BYTES - 1);
                    cmd_queue.push_back(cmd_read(a));
                end
                added += 4 + n + extra;
            end else if (r < 78) begin
                cmd_queue.push_back(random_cmd(OP_BEGIN));
                added++;
            end else if (r < 90) begin
                cmd_queue.push_back(random_cmd(OP_DATA));
                added++;
            end else if (r < 98) begin
                cmd_queue.push_back(random_cmd(OP_READ));
                added++;
            end else begin
                cmd_queue.push_back(random_cmd(OP_CLEAR));
                added++;
            end
        end
    endtask

    task automatic write_gray_mode(input logic v);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Sender stays quiet until every owed result is back; checked at the
    // rising edge, where the driver's queue and valid are already settled
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_if.valid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and run control
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.opcode        = OP_READ;
        cmd_if.pos_x         = '0;
        cmd_if.pos_y         = '0;
        cmd_if.sprite_width  = '0;
        cmd_if.sprite_height = '0;
        cmd_if.data_pair     = '0;
        cmd_if.read_address  = '0;
        res_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: edges of the buffer, rejections, clipping, gray as black
        write_gray_mode(1'b0);
        cmd_queue.push_back(cmd_read(0));
        cmd_queue.push_back(cmd_read(1023));
        cmd_queue.push_back(cmd_data(16'h1B1B));                 // no sprite yet
        cmd_queue.push_back(cmd_begin(-32768, 0, 255, 8));       // left of screen
        cmd_queue.push_back(cmd_begin(128, 0, 8, 8));            // right of screen
        cmd_queue.push_back(cmd_begin(0, 64, 8, 8));             // below screen
        cmd_queue.push_back(cmd_begin(0, -32768, 8, 0));         // above screen
        cmd_queue.push_back(cmd_begin(32767, 32767, 255, 255));
        cmd_queue.push_back(cmd_begin(-5, -3, 16, 16));          // negative origin
        cmd_queue.push_back(cmd_data(16'h0000));
        cmd_queue.push_back(cmd_data(16'hFFFF));
        cmd_queue.push_back(cmd_data(16'hAAAA));
        cmd_queue.push_back(cmd_data(16'h5555));
        cmd_queue.push_back(cmd_data(16'h1B1B));
        cmd_queue.push_back(cmd_begin(124, 61, 2, 4));           // one pair, bottom right
        cmd_queue.push_back(cmd_data(16'hAAAA));
        cmd_queue.push_back(cmd_data(16'h0000));                 // past the last pair
        cmd_queue.push_back(cmd_begin(0, 0, 0, 255));            // zero pairs
        cmd_queue.push_back(cmd_data(16'hAAAA));
        cmd_queue.push_back(cmd_begin(-255, -255, 255, 255));    // just touches screen
        cmd_queue.push_back(cmd_data(16'hAAAA));
        cmd_queue.push_back(cmd_read(0));
        cmd_queue.push_back(cmd_read(3));
        cmd_queue.push_back(cmd_read(1020));
        cmd_queue.push_back(random_cmd(OP_CLEAR));
        cmd_queue.push_back(cmd_read(1023));
        wait_drained();

        // Gray drawn white, then random traffic
        write_gray_mode(1'b1);
        cmd_queue.push_back(cmd_begin(0, 0, 8, 8));
        cmd_queue.push_back(cmd_data(16'h5555));
        cmd_queue.push_back(cmd_read(0));
        add_random_items(100);
        wait_drained();

        write_gray_mode(1'b0);
        add_random_items(200);
        wait_drained();

        write_gray_mode(1'b1);
        add_random_items(200);
        wait_drained();

        write_gray_mode(1'($urandom_range(0, 1)));
        add_random_items(30);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("two_bit_sprite_blitter_unit_test: done, clean");
        else
            $display("two_bit_sprite_blitter_unit_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            tx_gap       <= 0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (tx_gap != 0) begin
                cmd_if.valid <= 1'b0;
                tx_gap       <= tx_gap - 1;
            end else if (cmd_queue.size() != 0) begin
                next_cmd              = cmd_queue.pop_front();
                cmd_if.opcode        <= next_cmd.opcode;
                cmd_if.pos_x         <= next_cmd.pos_x;
                cmd_if.pos_y         <= next_cmd.pos_y;
                cmd_if.sprite_width  <= next_cmd.sprite_width;
                cmd_if.sprite_height <= next_cmd.sprite_height;
                cmd_if.data_pair     <= next_cmd.data_pair;
                cmd_if.read_address  <= next_cmd.read_address;
                cmd_if.valid         <= 1'b1;
                tx_gap <= (calm_stretch || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls plus two long hold-offs
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait      <= 0;
        end else if (rx_wait != 0) begin
            res_if.ready <= 1'b0;
            rx_wait      <= rx_wait - 1;
        end else if (result_count >= next_hold_at) begin
            res_if.ready <= 1'b0;
            rx_wait      <= LONG_HOLD;
            next_hold_at <= (next_hold_at == FIRST_HOLD) ? SECOND_HOLD : NO_MORE_HOLDS;
        end else if (!calm_stretch && $urandom_range(0, 99) < 20) begin
            res_if.ready <= 1'b0;
            rx_wait      <= pick_gap() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted command, check each result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
            for (int i = 0; i < FB_BYTES; i++)
                frame_model[i] = 8'h00;
            org_x      = 0;
            org_y      = 0;
            held_w     = 0;
            col_cnt    = 0;
            band_cnt   = 0;
            pairs_left = 0;
            sprite_on  = 1'b0;
            gray_white = 1'b0;
        end else begin
            cmd_taken <= cmd_if.valid && cmd_if.ready;
            if (cfg_if.valid && cfg_if.ready)
                gray_white = cfg_if.data;
            if (cmd_if.valid && cmd_if.ready) begin
                seen_cmd.opcode        = cmd_if.opcode;
                seen_cmd.pos_x         = cmd_if.pos_x;
                seen_cmd.pos_y         = cmd_if.pos_y;
                seen_cmd.sprite_width  = cmd_if.sprite_width;
                seen_cmd.sprite_height = cmd_if.sprite_height;
                seen_cmd.data_pair     = cmd_if.data_pair;
                seen_cmd.read_address  = cmd_if.read_address;
                pending_results.push_back(apply_command(seen_cmd));
            end
            if (res_if.valid && res_if.ready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    $error("result with no command outstanding: read_data %0h rejected %0b",
                           res_if.read_data, res_if.rejected);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.read_data !== want.read_data) begin
                        $error("read_data mismatch: expected %0h, got %0h",
                               want.read_data, res_if.read_data);
                        err_count++;
                    end
                    if (res_if.rejected !== want.rejected) begin
                        $error("rejected mismatch: expected %0b, got %0b",
                               want.rejected, res_if.rejected);
                        err_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transaction on any channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("two_bit_sprite_blitter_unit_test: done, errors");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_if.sv
hw/rtl/tsb_dp.sv
hw/rtl/tsb_ctrl.sv
hw/rtl/two_bit_sprite_blitter_unit.sv
test/two_bit_sprite_blitter_unit_test.sv
